@@ sv/assert_macros.svh @@
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds in the same cycle.
`define SWVT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define SWVT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/swvt_pkg.sv @@
// Shared constants, codes and controller/datapath interface types.
package swvt_pkg;

   localparam int CAPACITY_DEF  = 64;
   localparam int FRAC_BITS_DEF = 16;

   localparam int CMD_W    = 3;
   localparam int KEY_W    = 32;
   localparam int WT_W     = 32;
   localparam int IDX_W    = 6;
   localparam int STAT_W   = 2;
   localparam int RCOUNT_W = 7;
   localparam int OP_W     = 5;

   localparam logic [CMD_W-1:0] CMD_ADD        = 3'd0;
   localparam logic [CMD_W-1:0] CMD_ADD_ABSENT = 3'd1;
   localparam logic [CMD_W-1:0] CMD_NORM       = 3'd2;
   localparam logic [CMD_W-1:0] CMD_READ       = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd4;

   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

   localparam logic NORM_L1 = 1'b0;
   localparam logic NORM_L2 = 1'b1;

   // datapath operations
   localparam logic [OP_W-1:0] OP_NOP       = 5'd0;
   localparam logic [OP_W-1:0] OP_LOAD      = 5'd1;
   localparam logic [OP_W-1:0] OP_READ      = 5'd2;
   localparam logic [OP_W-1:0] OP_READ_IDX  = 5'd3;
   localparam logic [OP_W-1:0] OP_INC       = 5'd4;
   localparam logic [OP_W-1:0] OP_ADD_WR    = 5'd5;
   localparam logic [OP_W-1:0] OP_SET_POS   = 5'd6;
   localparam logic [OP_W-1:0] OP_INSERT    = 5'd7;
   localparam logic [OP_W-1:0] OP_READ_PREV = 5'd8;
   localparam logic [OP_W-1:0] OP_SHIFT_WR  = 5'd9;
   localparam logic [OP_W-1:0] OP_CLEAR     = 5'd10;
   localparam logic [OP_W-1:0] OP_SQUARE    = 5'd11;
   localparam logic [OP_W-1:0] OP_ACC_L1    = 5'd12;
   localparam logic [OP_W-1:0] OP_ACC_L2    = 5'd13;
   localparam logic [OP_W-1:0] OP_SQRT_INIT = 5'd14;
   localparam logic [OP_W-1:0] OP_SQRT_STEP = 5'd15;
   localparam logic [OP_W-1:0] OP_NORM_L1   = 5'd16;
   localparam logic [OP_W-1:0] OP_NORM_ROOT = 5'd17;
   localparam logic [OP_W-1:0] OP_DIV_START = 5'd18;
   localparam logic [OP_W-1:0] OP_DIV_WR    = 5'd19;
   localparam logic [OP_W-1:0] OP_RESP      = 5'd20;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [STAT_W-1:0] status;
      logic              ins;
      logic              rd;
   } dp_cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             kind;
      logic             at_end;
      logic             at_pos;
      logic             key_lt;
      logic             key_eq;
      logic             full;
      logic             idx_ok;
      logic             norm_zero;
      logic             sqrt_done;
      logic             div_done;
      logic             out_free;
   } dp_stat_type;

endpackage

@@ sv/swvt_div.sv @@
// Restoring divider, one quotient bit per cycle.
module swvt_div #(
   parameter int DVD_W = 48,
   parameter int DVS_W = 39
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);
   localparam int CW = $clog2(DVD_W + 1);

   logic [DVS_W-1:0] rem_ff;
   logic [DVD_W-1:0] quo_ff;
   logic [DVS_W-1:0] dvs_ff;
   logic [CW-1:0]    cnt_ff;
   logic [DVS_W:0]   trial;
   logic             fits;

   assign trial = {rem_ff, quo_ff[DVD_W-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         cnt_ff <= CW'(DVD_W);
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dvs_ff <= divisor;
      end else if (cnt_ff != '0) begin
         rem_ff <= fits ? DVS_W'(trial - {1'b0, dvs_ff}) : DVS_W'(trial);
         quo_ff <= {quo_ff[DVD_W-2:0], fits};
      end
   end

   assign done     = cnt_ff == '0;
   assign quotient = quo_ff;
endmodule

@@ sv/swvt_dp.sv @@
// Datapath: entry memories, scan pointer, norm accumulator, square root and divider.
module swvt_dp #(
   parameter int CAPACITY  = 64,
   parameter int FRAC_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  swvt_pkg::dp_cmd_type         ctl,
   output swvt_pkg::dp_stat_type        st,
   input  logic [swvt_pkg::CMD_W-1:0]   req_cmd,
   input  logic [swvt_pkg::KEY_W-1:0]   req_word_id,
   input  logic signed [swvt_pkg::WT_W-1:0] req_weight,
   input  logic                         req_norm_kind,
   input  logic [swvt_pkg::IDX_W-1:0]   req_entry_index,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [swvt_pkg::STAT_W-1:0]  rsp_status,
   output logic [swvt_pkg::RCOUNT_W-1:0] rsp_entry_count,
   output logic [swvt_pkg::KEY_W-1:0]   rsp_entry_id,
   output logic signed [swvt_pkg::WT_W-1:0] rsp_entry_value,
   output logic                         rsp_inserted
);
   import swvt_pkg::*;

   localparam int AW      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W   = $clog2(CAPACITY + 1);
   localparam int ROOT_W  = 32 + (CNT_W + 1) / 2;
   localparam int ACC_W   = 2 * ROOT_W;
   localparam int REM_W   = ROOT_W + 3;
   localparam int NORM_W  = 32 + CNT_W;
   localparam int DVD_W   = 32 + FRAC_BITS;
   localparam int SQ_CW   = $clog2(ROOT_W + 1);

   logic [KEY_W-1:0] key_mem [CAPACITY];
   logic [WT_W-1:0]  wt_mem  [CAPACITY];

   logic [CMD_W-1:0]  cmd_ff;
   logic [KEY_W-1:0]  id_ff;
   logic [WT_W-1:0]   w_ff;
   logic              kind_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  ptr_ff;
   logic [CNT_W-1:0]  pos_ff;
   logic [KEY_W-1:0]  key_rd_ff;
   logic [WT_W-1:0]   wt_rd_ff;
   logic [63:0]       sq_ff;
   logic [ACC_W-1:0]  acc_ff;
   logic [ACC_W-1:0]  sqv_ff;
   logic [REM_W-1:0]  rem_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [SQ_CW-1:0]  sq_cnt_ff;
   logic [NORM_W-1:0] norm_ff;
   logic              rsp_valid_ff;
   logic [STAT_W-1:0] rsp_status_ff;
   logic [RCOUNT_W-1:0] rsp_count_ff;
   logic [KEY_W-1:0]  rsp_id_ff;
   logic [WT_W-1:0]   rsp_val_ff;
   logic              rsp_ins_ff;

   logic [CNT_W-1:0]  ptr_m1;
   logic [AW-1:0]     rd_addr;
   logic              mem_rd;
   logic              key_we;
   logic              wt_we;
   logic [KEY_W-1:0]  key_wdata;
   logic [WT_W-1:0]   wt_wdata;
   logic [31:0]       mag;
   logic [WT_W:0]     sum33;
   logic [WT_W-1:0]   sat_sum;
   logic [REM_W-1:0]  sq_t;
   logic [REM_W-1:0]  sq_trial;
   logic              sq_fits;
   logic              div_start;
   logic              div_done;
   logic [DVD_W-1:0]  div_q;
   logic [32:0]       q_clamp;
   logic [WT_W-1:0]   div_val;

   assign ptr_m1 = ptr_ff - 1'b1;
   assign mag    = wt_rd_ff[WT_W-1] ? (32'd0 - wt_rd_ff) : wt_rd_ff;

   // saturating add onto the matched entry
   assign sum33   = {wt_rd_ff[WT_W-1], wt_rd_ff} + {w_ff[WT_W-1], w_ff};
   assign sat_sum = (sum33[WT_W] != sum33[WT_W-1]) ?
                    (sum33[WT_W] ? 32'h8000_0000 : 32'h7FFF_FFFF) : sum33[WT_W-1:0];

   // one digit pair of the integer square root per cycle
   assign sq_t     = {rem_ff[REM_W-3:0], sqv_ff[ACC_W-1 -: 2]};
   assign sq_trial = {1'b0, root_ff, 2'b01};
   assign sq_fits  = sq_t >= sq_trial;

   assign div_start = ctl.op == OP_DIV_START;

   swvt_div #(.DVD_W(DVD_W), .DVS_W(NORM_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({mag, FRAC_BITS'(0)}),
      .divisor  (norm_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign q_clamp = (div_q > DVD_W'(33'h1_0000_0000 >> 1)) ? 33'h0_8000_0000 : 33'(div_q);
   assign div_val = wt_rd_ff[WT_W-1] ? 32'(33'd0 - q_clamp) :
                    (q_clamp[31] ? 32'h7FFF_FFFF : q_clamp[31:0]);

   always_comb begin
      mem_rd    = 1'b0;
      rd_addr   = ptr_ff[AW-1:0];
      key_we    = 1'b0;
      wt_we     = 1'b0;
      key_wdata = key_rd_ff;
      wt_wdata  = wt_rd_ff;
      unique case (ctl.op)
         OP_READ: begin
            mem_rd = 1'b1;
         end
         OP_READ_IDX: begin
            mem_rd  = 1'b1;
            rd_addr = AW'(idx_ff);
         end
         OP_READ_PREV: begin
            mem_rd  = 1'b1;
            rd_addr = ptr_m1[AW-1:0];
         end
         OP_ADD_WR: begin
            wt_we    = 1'b1;
            wt_wdata = sat_sum;
         end
         OP_INSERT: begin
            key_we    = 1'b1;
            wt_we     = 1'b1;
            key_wdata = id_ff;
            wt_wdata  = w_ff;
         end
         OP_SHIFT_WR: begin
            key_we = 1'b1;
            wt_we  = 1'b1;
         end
         OP_DIV_WR: begin
            wt_we    = 1'b1;
            wt_wdata = div_val;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_rd) begin
         key_rd_ff <= key_mem[rd_addr];
         wt_rd_ff  <= wt_mem[rd_addr];
      end
      if (key_we) key_mem[ptr_ff[AW-1:0]] <= key_wdata;
      if (wt_we)  wt_mem[ptr_ff[AW-1:0]]  <= wt_wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         sq_cnt_ff    <= '0;
      end else begin
         rsp_valid_ff <= (ctl.op == OP_RESP) || (rsp_valid_ff && rsp_stall);
         unique case (ctl.op)
            OP_INSERT:    count_ff  <= count_ff + 1'b1;
            OP_CLEAR:     count_ff  <= '0;
            OP_SQRT_INIT: sq_cnt_ff <= SQ_CW'(ROOT_W);
            OP_SQRT_STEP: sq_cnt_ff <= sq_cnt_ff - 1'b1;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      unique case (ctl.op)
         OP_LOAD: begin
            cmd_ff  <= req_cmd;
            id_ff   <= req_word_id;
            w_ff    <= req_weight;
            kind_ff <= req_norm_kind;
            idx_ff  <= req_entry_index;
            ptr_ff  <= '0;
            acc_ff  <= '0;
         end
         OP_INC:      ptr_ff <= ptr_ff + 1'b1;
         OP_SET_POS: begin
            pos_ff <= ptr_ff;
            ptr_ff <= count_ff;
         end
         OP_SHIFT_WR: ptr_ff <= ptr_m1;
         OP_SQUARE:   sq_ff  <= mag * mag;
         OP_ACC_L1: begin
            acc_ff <= acc_ff + ACC_W'(mag);
            ptr_ff <= ptr_ff + 1'b1;
         end
         OP_ACC_L2: begin
            acc_ff <= acc_ff + ACC_W'(sq_ff);
            ptr_ff <= ptr_ff + 1'b1;
         end
         OP_SQRT_INIT: begin
            sqv_ff  <= acc_ff;
            rem_ff  <= '0;
            root_ff <= '0;
         end
         OP_SQRT_STEP: begin
            sqv_ff  <= sqv_ff << 2;
            rem_ff  <= sq_fits ? (sq_t - sq_trial) : sq_t;
            root_ff <= {root_ff[ROOT_W-2:0], sq_fits};
         end
         OP_NORM_L1: begin
            norm_ff <= NORM_W'(acc_ff);
            ptr_ff  <= '0;
         end
         OP_NORM_ROOT: begin
            norm_ff <= NORM_W'(root_ff);
            ptr_ff  <= '0;
         end
         OP_DIV_WR:   ptr_ff <= ptr_ff + 1'b1;
         OP_RESP: begin
            rsp_status_ff <= ctl.status;
            rsp_count_ff  <= RCOUNT_W'(count_ff);
            rsp_id_ff     <= ctl.rd ? key_rd_ff : '0;
            rsp_val_ff    <= ctl.rd ? wt_rd_ff : '0;
            rsp_ins_ff    <= ctl.ins;
         end
         default: ;
      endcase
   end

   always_comb begin
      st.cmd       = cmd_ff;
      st.kind      = kind_ff;
      st.at_end    = ptr_ff == count_ff;
      st.at_pos    = ptr_ff == pos_ff;
      st.key_lt    = key_rd_ff < id_ff;
      st.key_eq    = key_rd_ff == id_ff;
      st.full      = count_ff >= CNT_W'(CAPACITY);
      st.idx_ok    = {{CNT_W{1'b0}}, idx_ff} < {{IDX_W{1'b0}}, count_ff};
      st.norm_zero = norm_ff == '0;
      st.sqrt_done = sq_cnt_ff == '0;
      st.div_done  = div_done;
      st.out_free  = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_entry_id    = rsp_id_ff;
   assign rsp_entry_value = rsp_val_ff;
   assign rsp_inserted    = rsp_ins_ff;
endmodule

@@ sv/swvt_ctrl.sv @@
// Command sequencer: scan, shift-insert, indexed read, clear, normalize passes and response.
module swvt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  swvt_pkg::dp_stat_type st,
   output swvt_pkg::dp_cmd_type  ctl
);
   import swvt_pkg::*;

   localparam logic [4:0] S_IDLE    = 5'd0;
   localparam logic [4:0] S_DISP    = 5'd1;
   localparam logic [4:0] S_SCAN_RD = 5'd2;
   localparam logic [4:0] S_SCAN_CP = 5'd3;
   localparam logic [4:0] S_SH_RD   = 5'd4;
   localparam logic [4:0] S_SH_WR   = 5'd5;
   localparam logic [4:0] S_RD_WAIT = 5'd6;
   localparam logic [4:0] S_N1_RD   = 5'd7;
   localparam logic [4:0] S_N1_A    = 5'd8;
   localparam logic [4:0] S_N1_B    = 5'd9;
   localparam logic [4:0] S_SQRT    = 5'd10;
   localparam logic [4:0] S_N_CHK   = 5'd11;
   localparam logic [4:0] S_N2_RD   = 5'd12;
   localparam logic [4:0] S_N2_ST   = 5'd13;
   localparam logic [4:0] S_N2_WT   = 5'd14;
   localparam logic [4:0] S_RESP    = 5'd15;

   logic [4:0]        state_ff, state_in;
   logic [STAT_W-1:0] status_ff, status_in;
   logic              ins_ff, ins_in;
   logic              rd_ff, rd_in;

   always_comb begin
      state_in   = state_ff;
      status_in  = status_ff;
      ins_in     = ins_ff;
      rd_in      = rd_ff;
      ctl.op     = OP_NOP;
      ctl.status = status_ff;
      ctl.ins    = ins_ff;
      ctl.rd     = rd_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctl.op    = OP_LOAD;
               status_in = STAT_OK;
               ins_in    = 1'b0;
               rd_in     = 1'b0;
               state_in  = S_DISP;
            end
         end
         S_DISP: begin
            case (st.cmd) inside
               CMD_ADD, CMD_ADD_ABSENT: state_in = S_SCAN_RD;
               CMD_NORM:                state_in = S_N1_RD;
               CMD_READ: begin
                  if (st.idx_ok) begin
                     ctl.op   = OP_READ_IDX;
                     state_in = S_RD_WAIT;
                  end else begin
                     status_in = STAT_RANGE;
                     state_in  = S_RESP;
                  end
               end
               CMD_CLEAR: begin
                  ctl.op   = OP_CLEAR;
                  state_in = S_RESP;
               end
               default: state_in = S_RESP;
            endcase
         end
         S_SCAN_RD: begin
            if (st.at_end) begin
               if (st.full) begin
                  status_in = STAT_FULL;
                  state_in  = S_RESP;
               end else begin
                  ctl.op   = OP_SET_POS;
                  state_in = S_SH_RD;
               end
            end else begin
               ctl.op   = OP_READ;
               state_in = S_SCAN_CP;
            end
         end
         S_SCAN_CP: begin
            if (st.key_lt) begin
               ctl.op   = OP_INC;
               state_in = S_SCAN_RD;
            end else if (st.key_eq) begin
               if (st.cmd == CMD_ADD) ctl.op = OP_ADD_WR;
               state_in = S_RESP;
            end else if (st.full) begin
               status_in = STAT_FULL;
               state_in  = S_RESP;
            end else begin
               ctl.op   = OP_SET_POS;
               state_in = S_SH_RD;
            end
         end
         // shift entries up from the tail down to the insert position
         S_SH_RD: begin
            if (st.at_pos) begin
               ctl.op   = OP_INSERT;
               ins_in   = 1'b1;
               state_in = S_RESP;
            end else begin
               ctl.op   = OP_READ_PREV;
               state_in = S_SH_WR;
            end
         end
         S_SH_WR: begin
            ctl.op   = OP_SHIFT_WR;
            state_in = S_SH_RD;
         end
         S_RD_WAIT: begin
            rd_in    = 1'b1;
            state_in = S_RESP;
         end
         S_N1_RD: begin
            if (st.at_end) begin
               if (st.kind == NORM_L1) begin
                  ctl.op   = OP_NORM_L1;
                  state_in = S_N_CHK;
               end else begin
                  ctl.op   = OP_SQRT_INIT;
                  state_in = S_SQRT;
               end
            end else begin
               ctl.op   = OP_READ;
               state_in = S_N1_A;
            end
         end
         S_N1_A: begin
            if (st.kind == NORM_L1) begin
               ctl.op   = OP_ACC_L1;
               state_in = S_N1_RD;
            end else begin
               ctl.op   = OP_SQUARE;
               state_in = S_N1_B;
            end
         end
         S_N1_B: begin
            ctl.op   = OP_ACC_L2;
            state_in = S_N1_RD;
         end
         S_SQRT: begin
            if (st.sqrt_done) begin
               ctl.op   = OP_NORM_ROOT;
               state_in = S_N_CHK;
            end else begin
               ctl.op = OP_SQRT_STEP;
            end
         end
         S_N_CHK: begin
            state_in = st.norm_zero ? S_RESP : S_N2_RD;
         end
         S_N2_RD: begin
            if (st.at_end) begin
               state_in = S_RESP;
            end else begin
               ctl.op   = OP_READ;
               state_in = S_N2_ST;
            end
         end
         S_N2_ST: begin
            ctl.op   = OP_DIV_START;
            state_in = S_N2_WT;
         end
         S_N2_WT: begin
            if (st.div_done) begin
               ctl.op   = OP_DIV_WR;
               state_in = S_N2_RD;
            end
         end
         S_RESP: begin
            if (st.out_free) begin
               ctl.op   = OP_RESP;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         status_ff <= STAT_OK;
         ins_ff    <= 1'b0;
         rd_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
         ins_ff    <= ins_in;
         rd_ff     <= rd_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;
endmodule

@@ sv/sparse_word_vector_table.sv @@
// Add scans the entries below the key with a read and a compare each; insert shifts each moved
// entry with a read and a write. Normalize: a read and accumulate (L1) or a read, square and
// accumulate (L2) per entry for the norm, a serial L2 root, then the serial divider per entry.
// One word in flight at a time; the response register frees the input before it is taken.
// Synchronous active-high reset empties the table at once; entry memories are not cleared.
module sparse_word_vector_table #(
   parameter int CAPACITY  = swvt_pkg::CAPACITY_DEF,
   parameter int FRAC_BITS = swvt_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [swvt_pkg::CMD_W-1:0]        req_cmd,
   input  logic [swvt_pkg::KEY_W-1:0]        req_word_id,
   input  logic signed [swvt_pkg::WT_W-1:0]  req_weight,
   input  logic                              req_norm_kind,
   input  logic [swvt_pkg::IDX_W-1:0]        req_entry_index,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [swvt_pkg::STAT_W-1:0]       rsp_status,
   output logic [swvt_pkg::RCOUNT_W-1:0]     rsp_entry_count,
   output logic [swvt_pkg::KEY_W-1:0]        rsp_entry_id,
   output logic signed [swvt_pkg::WT_W-1:0]  rsp_entry_value,
   output logic                              rsp_inserted
);
   import swvt_pkg::*;

   dp_cmd_type  ctl;
   dp_stat_type st;

   swvt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .st        (st),
      .ctl       (ctl)
   );

   swvt_dp #(.CAPACITY(CAPACITY), .FRAC_BITS(FRAC_BITS)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .st              (st),
      .req_cmd         (req_cmd),
      .req_word_id     (req_word_id),
      .req_weight      (req_weight),
      .req_norm_kind   (req_norm_kind),
      .req_entry_index (req_entry_index),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count),
      .rsp_entry_id    (rsp_entry_id),
      .rsp_entry_value (rsp_entry_value),
      .rsp_inserted    (rsp_inserted)
   );
endmodule

@@ sv/swvt_checker.sv @@
// Port-level checks on the table, bound to the top level.
`include "assert_macros.svh"

module swvt_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [swvt_pkg::STAT_W-1:0]       rsp_status,
   input logic [swvt_pkg::RCOUNT_W-1:0]     rsp_entry_count,
   input logic [swvt_pkg::KEY_W-1:0]        rsp_entry_id,
   input logic signed [swvt_pkg::WT_W-1:0]  rsp_entry_value,
   input logic                              rsp_inserted
);
   import swvt_pkg::*;

   `SWVT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "response dropped while stalled")
   `SWVT_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall, "second word taken while busy")
   `SWVT_ASSERT(a_full_no_insert, clock, reset, !(rsp_valid && rsp_status == STAT_FULL && rsp_inserted), "insert flagged on full table")
   `SWVT_ASSERT(a_range_zero, clock, reset, !(rsp_valid && rsp_status == STAT_RANGE) || (rsp_entry_id == '0 && rsp_entry_value == '0), "out of range read returned data")
   `SWVT_ASSERT(a_insert_count, clock, reset, !(rsp_valid && rsp_inserted) || rsp_entry_count != '0, "insert left table empty")
endmodule

bind sparse_word_vector_table swvt_checker u_swvt_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_status      (rsp_status),
   .rsp_entry_count (rsp_entry_count),
   .rsp_entry_id    (rsp_entry_id),
   .rsp_entry_value (rsp_entry_value),
   .rsp_inserted    (rsp_inserted)
);
